// ----- rtl/lfu_cache_store_macros.svh -----
// Assertion helpers for the LFU store
`ifndef LFU_CACHE_STORE_MACROS_SVH
`define LFU_CACHE_STORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LFU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lfu_cache_store: same-cycle check failed");

// next-cycle implication, checked outside reset
`define LFU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lfu_cache_store: next-cycle check failed");

`endif

// ----- rtl/lfu_pkg.sv -----
package lfu_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int FILL_W  = $clog2(ENTRIES + 1);
   localparam int CAP_W   = 5;
   localparam int DATA_W  = 32;

   localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
   localparam logic [DATA_W-1:0] SAT_MAX   = '1;

   // request command codes
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_RESP
   } state_type;

   // result of one step of the shared scan unit
   typedef struct packed {
      logic [DATA_W-1:0] aged;
      logic              match;
      logic              better;
   } scan_res_type;

   function automatic logic [DATA_W-1:0] sat_inc(input logic [DATA_W-1:0] x);
      return (x == SAT_MAX) ? x : x + DATA_W'(1);
   endfunction

endpackage

// ----- rtl/lfu_scan_unit.sv -----
// One entry per cycle: age it, compare its key, rank it as a victim candidate.
module lfu_scan_unit (
   input  logic [lfu_pkg::DATA_W-1:0] entry_key,
   input  logic [lfu_pkg::DATA_W-1:0] probe_key,
   input  logic [lfu_pkg::DATA_W-1:0] entry_count,
   input  logic [lfu_pkg::DATA_W-1:0] entry_age,
   input  logic [lfu_pkg::DATA_W-1:0] best_count,
   input  logic [lfu_pkg::DATA_W-1:0] best_age,
   input  logic                       first,
   output lfu_pkg::scan_res_type      res
);

   logic [lfu_pkg::DATA_W-1:0] aged;

   assign aged = lfu_pkg::sat_inc(entry_age);

   always_comb begin
      res.aged   = aged;
      res.match  = (entry_key == probe_key);
      // lower count wins; on a tie the older one, earlier index kept on equal age
      res.better = first || (entry_count < best_count) ||
                   ((entry_count == best_count) && (aged > best_age));
   end

endmodule

// ----- rtl/lfu_cache_store.sv -----
// Flow: an accepted request is scanned, then updated, then answered on rsp_valid
// (each filled entry in turn through the shared scan unit, then scan end and update).
// One request at a time: not ready while busy, until the response is taken.
// Reset (synchronous, active high): store empty, capacity 16, idle and ready.
// Entry contents are not cleared; only entries below the fill count are read.
module lfu_cache_store (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_command,
   input  logic [lfu_pkg::DATA_W-1:0] req_key,
   input  logic [lfu_pkg::DATA_W-1:0] req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_hit,
   output logic [lfu_pkg::DATA_W-1:0] rsp_read_value,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [lfu_pkg::CAP_W-1:0]  csr_capacity_in_use
);

`include "lfu_cache_store_macros.svh"

   localparam int DW = lfu_pkg::DATA_W;
   localparam int IW = lfu_pkg::IDX_W;
   localparam int FW = lfu_pkg::FILL_W;

   logic [DW-1:0] keys_mem   [lfu_pkg::ENTRIES];
   logic [DW-1:0] values_mem [lfu_pkg::ENTRIES];
   logic [DW-1:0] counts_mem [lfu_pkg::ENTRIES];
   logic [DW-1:0] ages_mem   [lfu_pkg::ENTRIES];

   lfu_pkg::state_type state_ff, state_in;
   logic [FW-1:0]  idx_ff, idx_in;
   logic [FW-1:0]  fill_ff, fill_in;
   logic [lfu_pkg::CAP_W-1:0] cap_ff;
   logic           cmd_ff;
   logic [DW-1:0]  key_ff, val_ff;
   logic           hit_ff, hit_in;
   logic [IW-1:0]  hit_idx_ff, hit_idx_in;
   logic [IW-1:0]  best_idx_ff, best_idx_in;
   logic [DW-1:0]  best_count_ff, best_count_in;
   logic [DW-1:0]  best_age_ff, best_age_in;
   logic           rsp_hit_ff, rsp_hit_in;
   logic [DW-1:0]  rsp_value_ff, rsp_value_in;

   logic [IW-1:0]  rd_addr, wr_addr;
   logic [DW-1:0]  key_rd_ff, val_rd_ff, cnt_rd_ff, age_rd_ff;
   logic           key_we, val_we, cnt_we, age_we;
   logic [DW-1:0]  cnt_wdata, age_wdata;
   logic [FW-1:0]  eff_cap;
   logic           accept;
   lfu_pkg::scan_res_type scan_res;

   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = (state_ff == lfu_pkg::ST_RESP);
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_value_ff;

   // registered read, addressed from the next-state values: next scan index, or the hit slot
   // for the update
   assign rd_addr = (state_in == lfu_pkg::ST_UPDATE) ? hit_idx_in : idx_in[IW-1:0];

   assign eff_cap = (int'(cap_ff) > lfu_pkg::ENTRIES) ? FW'(lfu_pkg::ENTRIES) : FW'(cap_ff);

   lfu_scan_unit u_scan (
      .entry_key   (key_rd_ff),
      .probe_key   (key_ff),
      .entry_count (cnt_rd_ff),
      .entry_age   (age_rd_ff),
      .best_count  (best_count_ff),
      .best_age    (best_age_ff),
      .first       (idx_ff == '0),
      .res         (scan_res)
   );

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      fill_in       = fill_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      best_idx_in   = best_idx_ff;
      best_count_in = best_count_ff;
      best_age_in   = best_age_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_value_in  = rsp_value_ff;
      req_ready     = 1'b0;
      wr_addr       = idx_ff[IW-1:0];
      key_we        = 1'b0;
      val_we        = 1'b0;
      cnt_we        = 1'b0;
      age_we        = 1'b0;
      cnt_wdata     = DW'(1);
      age_wdata     = DW'(1);
      case (state_ff)
         lfu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               idx_in   = '0;
               hit_in   = 1'b0;
               state_in = lfu_pkg::ST_SCAN;
            end
         end
         lfu_pkg::ST_SCAN: begin
            if (idx_ff == fill_ff) begin
               state_in = lfu_pkg::ST_UPDATE;
            end else begin
               age_we    = 1'b1;
               age_wdata = scan_res.aged;
               if (scan_res.match && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = idx_ff[IW-1:0];
               end
               if (scan_res.better) begin
                  best_idx_in   = idx_ff[IW-1:0];
                  best_count_in = cnt_rd_ff;
                  best_age_in   = scan_res.aged;
               end
               idx_in = idx_ff + FW'(1);
            end
         end
         lfu_pkg::ST_UPDATE: begin
            state_in     = lfu_pkg::ST_RESP;
            rsp_hit_in   = hit_ff;
            rsp_value_in = '0;
            if (hit_ff) begin
               wr_addr   = hit_idx_ff;
               cnt_we    = 1'b1;
               cnt_wdata = lfu_pkg::sat_inc(cnt_rd_ff);
               age_we    = 1'b1;
               if (cmd_ff == lfu_pkg::CMD_PUT) begin
                  val_we = 1'b1;
               end else begin
                  rsp_value_in = val_rd_ff;
               end
            end else if (cmd_ff == lfu_pkg::CMD_PUT) begin
               if (fill_ff < eff_cap) begin
                  wr_addr = fill_ff[IW-1:0];
                  fill_in = fill_ff + FW'(1);
                  key_we  = 1'b1;
                  val_we  = 1'b1;
                  cnt_we  = 1'b1;
                  age_we  = 1'b1;
               end else if (eff_cap != '0 && fill_ff != '0) begin
                  // evict the least used, oldest entry
                  wr_addr = best_idx_ff;
                  key_we  = 1'b1;
                  val_we  = 1'b1;
                  cnt_we  = 1'b1;
                  age_we  = 1'b1;
               end
            end
         end
         lfu_pkg::ST_RESP: begin
            if (rsp_ready) begin
               state_in = lfu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lfu_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lfu_pkg::ST_IDLE;
         fill_ff  <= '0;
         cap_ff   <= lfu_pkg::CAP_RESET;
         idx_ff   <= '0;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         idx_ff   <= idx_in;
         hit_ff   <= hit_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_capacity_in_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_command;
         key_ff <= req_key;
         val_ff <= req_value;
      end
      hit_idx_ff    <= hit_idx_in;
      best_idx_ff   <= best_idx_in;
      best_count_ff <= best_count_in;
      best_age_ff   <= best_age_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_value_ff  <= rsp_value_in;
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         keys_mem[wr_addr] <= key_ff;
      end
      if (val_we) begin
         values_mem[wr_addr] <= val_ff;
      end
      if (cnt_we) begin
         counts_mem[wr_addr] <= cnt_wdata;
      end
      if (age_we) begin
         ages_mem[wr_addr] <= age_wdata;
      end
      key_rd_ff <= keys_mem[rd_addr];
      val_rd_ff <= values_mem[rd_addr];
      cnt_rd_ff <= counts_mem[rd_addr];
      age_rd_ff <= ages_mem[rd_addr];
   end

   `LFU_ASSERT_NOW(a_fill_bound, 1'b1, fill_ff <= FW'(lfu_pkg::ENTRIES))
   `LFU_ASSERT_NOW(a_no_overlap, rsp_valid, !req_ready)
   `LFU_ASSERT_NEXT(a_busy_after_accept, accept, !req_ready && !rsp_valid)
   `LFU_ASSERT_NEXT(a_fill_step, state_ff != lfu_pkg::ST_UPDATE, fill_ff == $past(fill_ff))

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam int   DATA_W       = lfu_pkg::DATA_W;
   localparam int   CAP_W        = lfu_pkg::CAP_W;
   localparam int   ENTRIES      = lfu_pkg::ENTRIES;
   localparam logic CMD_GET      = lfu_pkg::CMD_GET;
   localparam logic CMD_PUT      = lfu_pkg::CMD_PUT;
   localparam int   PHASES       = 13;
   localparam int   PHASE_WORDS  = 100;
   localparam int   POOL_SIZE    = 20;
   localparam int   HOLD_PHASE   = 9;
   localparam int   HOLD_CYCLES  = 300;
   localparam int   STALL_LIMIT  = 2000;
   localparam int   TAIL_CYCLES  = 25;
   localparam int   DIRECTED_ROWS = 23;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic              hit;
      logic [DATA_W-1:0] read_value;
   } lookup_word_type;

   typedef struct packed {
      row_kind_type      kind;
      logic              cmd;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] data;
      logic [CAP_W-1:0]  cap;
      logic              typed;
      logic              exp_hit;
      logic [DATA_W-1:0] exp_rd;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_command;
   logic [DATA_W-1:0] req_key;
   logic [DATA_W-1:0] req_value;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_hit;
   logic [DATA_W-1:0] rsp_read_value;
   logic              csr_valid;
   logic              csr_ready;
   logic [CAP_W-1:0]  csr_capacity_in_use;

   // shadow copy of the store
   logic [DATA_W-1:0] mdl_key [ENTRIES];
   logic [DATA_W-1:0] mdl_val [ENTRIES];
   logic [DATA_W-1:0] mdl_cnt [ENTRIES];
   logic [DATA_W-1:0] mdl_age [ENTRIES];
   int                mdl_fill;
   logic [CAP_W-1:0]  mdl_cap;

   lookup_word_type   pending_lookups [$];
   logic              word_typed;
   lookup_word_type   word_want;
   int                req_count;
   int                rsp_count;
   int                mismatches;
   int                req_idle_pct;
   int                rsp_idle_pct;
   int                hold_off_cycles;
   int                stall_cycles;

   stim_row_type      directed_rows [DIRECTED_ROWS];
   logic [CAP_W-1:0]  phase_caps [PHASES];

   lfu_cache_store dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_key             (req_key),
      .req_value           (req_value),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_hit             (rsp_hit),
      .rsp_read_value      (rsp_read_value),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_capacity_in_use (csr_capacity_in_use)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one access: age, look up, then update or insert / evict
   task automatic lfu_access(input logic put, input logic [DATA_W-1:0] k,
                             input logic [DATA_W-1:0] d, output lookup_word_type res);
      int cap_eff;
      int slot;
      res = '0;
      slot = -1;
      cap_eff = (mdl_cap > ENTRIES) ? ENTRIES : int'(mdl_cap);
      for (int i = 0; i < mdl_fill; i++)
         if (mdl_age[i] != '1) mdl_age[i] = mdl_age[i] + 1'b1;
      for (int i = 0; i < mdl_fill; i++)
         if (slot < 0 && mdl_key[i] == k) slot = i;
      if (slot >= 0) begin
         if (mdl_cnt[slot] != '1) mdl_cnt[slot] = mdl_cnt[slot] + 1'b1;
         mdl_age[slot] = 1;
         res.hit = 1'b1;
         if (put) mdl_val[slot] = d;
         else res.read_value = mdl_val[slot];
      end else if (put) begin
         if (mdl_fill < cap_eff) begin
            slot = mdl_fill;
            mdl_fill++;
         end else if (cap_eff > 0 && mdl_fill > 0) begin
            // least used, oldest among ties, lowest index on equal age
            slot = 0;
            for (int i = 1; i < mdl_fill; i++)
               if (mdl_cnt[i] < mdl_cnt[slot] ||
                   (mdl_cnt[i] == mdl_cnt[slot] && mdl_age[i] > mdl_age[slot]))
                  slot = i;
         end
         if (slot >= 0) begin
            mdl_key[slot] = k;
            mdl_val[slot] = d;
            mdl_cnt[slot] = 1;
            mdl_age[slot] = 1;
         end
      end
   endtask

   // monitor: predict on request words, check response words
   always @(posedge clock) begin
      lookup_word_type got;
      lookup_word_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) mdl_cap = csr_capacity_in_use;
         if (req_valid && req_ready) begin
            lfu_access(req_command, req_key, req_value, want);
            pending_lookups.push_back(word_typed ? word_want : want);
         end
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            got = '{hit: rsp_hit, read_value: rsp_read_value};
            if (pending_lookups.size() == 0) begin
               $display("%0t: unexpected word, hit %0b read_value %h",
                        $time, got.hit, got.read_value);
               mismatches++;
            end else begin
               want = pending_lookups.pop_front();
               if (got.hit !== want.hit) begin
                  $display("%0t: hit mismatch, expected %0b, actual %0b",
                           $time, want.hit, got.hit);
                  mismatches++;
               end
               if (got.read_value !== want.read_value) begin
                  $display("%0t: read_value mismatch, expected %h, actual %h",
                           $time, want.read_value, got.read_value);
                  mismatches++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   // response side backpressure, with an occasional long hold-off
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic push_word(input logic cmd, input logic [DATA_W-1:0] k,
                            input logic [DATA_W-1:0] d, input logic typed,
                            input lookup_word_type want);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_key     <= k;
      req_value   <= d;
      word_typed  <= typed;
      word_want   <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      req_count++;
   endtask

   // only while idle: every issued word has its response
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      req_valid <= 1'b0;
      while (rsp_count != req_count) @(posedge clock);
      csr_valid           <= 1'b1;
      csr_capacity_in_use <= cap;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      lookup_word_type   want;
      logic [DATA_W-1:0] key_pool [POOL_SIZE];
      logic [DATA_W-1:0] k;
      logic [CAP_W-1:0]  cap;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_command         = CMD_GET;
      req_key             = '0;
      req_value           = '0;
      csr_valid           = 1'b0;
      csr_capacity_in_use = '0;
      word_typed          = 1'b0;
      word_want           = '0;
      req_count           = 0;
      rsp_count           = 0;
      mismatches          = 0;
      hold_off_cycles     = 0;
      stall_cycles        = 0;
      mdl_fill            = 0;
      mdl_cap             = lfu_pkg::CAP_RESET;
      foreach (mdl_key[i]) begin
         mdl_key[i] = '0;
         mdl_val[i] = '0;
         mdl_cnt[i] = '0;
         mdl_age[i] = '0;
      end
      req_idle_pct = 11;
      rsp_idle_pct = 88;
      phase_caps = '{5'd16, 5'd4, 5'd31, 5'd0, 5'd1, 5'd17, 5'd8,
                     5'd16, 5'd2, 5'd31, 5'd0, 5'd12, 5'd16};
      // kind, cmd, key, data, cap, typed, hit, read_value
      directed_rows = '{
         '{ROW_REQ, CMD_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b0, 32'h0},
         '{ROW_REQ, CMD_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 5'd0, 1'b1, 1'b0, 32'h0},
         '{ROW_REQ, CMD_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b1, 32'hFFFF_FFFF},
         '{ROW_REQ, CMD_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0, 1'b1, 1'b0, 32'h0},
         '{ROW_REQ, CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 1'b1, 1'b1, 32'h0},
         '{ROW_REQ, CMD_PUT, 32'h0000_0000, 32'h0F0F_0F0F, 5'd0, 1'b1, 1'b1, 32'h0},
         '{ROW_REQ, CMD_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b1, 1'b1, 32'h0F0F_0F0F},
         // shrink to the fill level: new key must evict
         '{ROW_CSR, CMD_GET, 32'h0000_0000, 32'h0000_0000, 5'd2, 1'b0, 1'b0, 32'h0},
         '{ROW_REQ, CMD_PUT, 32'h0000_0011, 32'h0000_0011, 5'd0, 1'b0, 1'b0, 32'h0},
         '{ROW_REQ, CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
         '{ROW_REQ, CMD_GET, 32'h0000_0011, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
         // zero capacity: no insert, but updates still land
         '{ROW_CSR, CMD_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
         '{ROW_REQ, CMD_PUT, 32'h0000_0022, 32'h1234_5678, 5'd0, 1'b1, 1'b0, 32'h0},
         '{ROW_REQ, CMD_GET, 32'h0000_0022, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
         '{ROW_REQ, CMD_PUT, 32'h0000_0011, 32'hAAAA_5555, 5'd0, 1'b0, 1'b0, 32'h0},
         '{ROW_REQ, CMD_GET, 32'h0000_0011, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
         // below the fill level: victim among all filled entries
         '{ROW_CSR, CMD_GET, 32'h0000_0000, 32'h0000_0000, 5'd1, 1'b0, 1'b0, 32'h0},
         '{ROW_REQ, CMD_PUT, 32'h0000_0033, 32'h5555_AAAA, 5'd0, 1'b0, 1'b0, 32'h0},
         '{ROW_REQ, CMD_GET, 32'h0000_0000, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0},
         // above the slot count clamps to a full store
         '{ROW_CSR, CMD_GET, 32'h0000_0000, 32'h0000_0000, 5'd31, 1'b0, 1'b0, 32'h0},
         '{ROW_REQ, CMD_PUT, 32'h0000_0044, 32'hC3C3_3C3C, 5'd0, 1'b0, 1'b0, 32'h0},
         '{ROW_CSR, CMD_GET, 32'h0000_0000, 32'h0000_0000, 5'd16, 1'b0, 1'b0, 32'h0},
         '{ROW_REQ, CMD_GET, 32'h0000_0044, 32'h0000_0000, 5'd0, 1'b0, 1'b0, 32'h0}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_CSR) begin
            write_capacity(directed_rows[r].cap);
         end else begin
            want = '{hit: directed_rows[r].exp_hit, read_value: directed_rows[r].exp_rd};
            push_word(directed_rows[r].cmd, directed_rows[r].key, directed_rows[r].data,
                      directed_rows[r].typed, want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         req_idle_pct = (ph < 4) ? 11 : ((ph < 8) ? 88 : 0);
         rsp_idle_pct = (ph < 4) ? 88 : ((ph < 8) ? 11 : 0);
         cap = (ph == 7) ? CAP_W'($urandom_range(31)) : phase_caps[ph];
         write_capacity(cap);
         // keep part of the old key set so older entries still get hits
         foreach (key_pool[i]) begin
            if (ph == 0 || $urandom_range(1) == 1) begin
               case ($urandom_range(9))
                  0:       key_pool[i] = '0;
                  1:       key_pool[i] = '1;
                  default: key_pool[i] = $urandom();
               endcase
            end
         end
         if (ph == HOLD_PHASE) hold_off_cycles = HOLD_CYCLES;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                          : DATA_W'($urandom());
            push_word($urandom_range(1) == 1 ? CMD_PUT : CMD_GET, k, $urandom(), 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      while (rsp_count != req_count) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_lookups.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_lookups.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
